[src/tts_pkg.sv]
`timescale 1ns / 1ps

package tts_pkg;

  // field widths
  localparam int OP_W   = 2;
  localparam int TAG_W  = 8;
  localparam int TIME_W = 16;
  localparam int TID_W  = 8;
  localparam int ID_W   = 7;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD      = 2'd2;
  localparam logic [OP_W-1:0] OP_DELETE   = 2'd3;

  // kinds of result pushed into the output register
  localparam logic [2:0] PUSH_NONE   = 3'd0;
  localparam logic [2:0] PUSH_ADD_OK = 3'd1;
  localparam logic [2:0] PUSH_FAIL   = 3'd2;
  localparam logic [2:0] PUSH_DEL    = 3'd3;
  localparam logic [2:0] PUSH_HOLD   = 3'd4;
  localparam logic [2:0] PUSH_FINAL  = 3'd5;

  // one slot entry in the table memory
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
  } ent_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_en;
    logic       tick_upd;
    logic       disp_upd;
    logic       add_take;
    logic [2:0] push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic [OP_W-1:0] op;
    logic            slot_used;
    logic            slot_ready;
    logic            idx_last;
    logic            out_free;
    logic            tag_zero;
    logic            hold_valid;
  } sts_t;

endpackage

[src/tts_ctrl.sv]
`timescale 1ns / 1ps

module tts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tts_pkg::sts_t sts,
  output tts_pkg::cmd_t cmd
);
  import tts_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_PROC   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept  = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = (sts.in_op == OP_DELETE) ? ST_FINISH : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.op == OP_ADD) begin
          if (sts.tag_zero) begin
            state_nxt = ST_FINISH;
          end else if (!sts.slot_used) begin
            // first free slot: take it once the result can be stored
            if (sts.out_free) begin
              cmd.add_take = 1'b1;
              cmd.push     = PUSH_ADD_OK;
              state_nxt    = ST_IDLE;
            end
          end else if (sts.idx_last) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else if (sts.slot_used &&
                     (sts.op == OP_TICK || sts.slot_ready)) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_PROC;
        end else if (sts.idx_last) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_PROC: begin
        // a dispatch waits while an earlier result still blocks the output
        if (sts.op == OP_TICK || !sts.hold_valid || sts.out_free) begin
          if (sts.op == OP_TICK) begin
            cmd.tick_upd = 1'b1;
          end else begin
            cmd.disp_upd = 1'b1;
            cmd.push     = sts.hold_valid ? PUSH_HOLD : PUSH_NONE;
          end
          if (sts.idx_last) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_CHECK;
          end
        end
      end
      ST_FINISH: begin
        if (sts.op == OP_TICK) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          case (sts.op)
            OP_DISPATCH: cmd.push = PUSH_FINAL;
            OP_DELETE:   cmd.push = PUSH_DEL;
            default:     cmd.push = PUSH_FAIL;
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/tts_dp.sv]
`timescale 1ns / 1ps

module tts_dp #(
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tts_pkg::IN_W-1:0]    in_tdata,
  input  logic [tts_pkg::OP_W-1:0]    in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tts_pkg::OUT_W-1:0]   out_tdata,
  output logic                        out_tlast,
  input  tts_pkg::cmd_t               cmd,
  output tts_pkg::sts_t               sts
);
  import tts_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // latched input item
  logic [OP_W-1:0]   op_r;
  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] dly_r;
  logic [TIME_W-1:0] per_r;
  logic [TID_W-1:0]  tid_r;

  // slot walk and per-slot flags
  logic [IDX_W-1:0]  idx_r;
  logic [SLOTS-1:0]  used_r;
  logic [SLOTS-1:0]  ready_r;

  // table memory with registered read
  ent_t              mem [SLOTS];
  ent_t              rd_q_r;
  logic              mem_we;
  ent_t              mem_wd;

  // dispatch result held back until its successor or the end is known
  logic              hold_v_r;
  logic [ID_W-1:0]   hold_id_r;
  logic [TAG_W-1:0]  hold_tag_r;

  // output register
  logic              out_v_r;
  logic [ID_W-1:0]   out_id_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic              out_ok_r;
  logic              out_last_r;

  logic              out_free;
  logic              del_ok;
  logic [IDX_W-1:0]  del_idx;
  logic [ID_W-1:0]   cur_id;
  logic              push_v;
  logic [ID_W-1:0]   push_id;
  logic [TAG_W-1:0]  push_tag;
  logic              push_ok;
  logic              push_last;

  assign out_free = !out_v_r || out_tready;
  assign cur_id   = ID_W'(idx_r) + 7'd1;
  assign del_idx  = IDX_W'(tid_r - 8'd1);
  assign del_ok   = (tid_r != 8'd0) && (tid_r <= TID_W'(SLOTS)) && used_r[del_idx];

  // status to the controller
  always_comb begin
    sts.in_op      = in_tuser;
    sts.op         = op_r;
    sts.slot_used  = used_r[idx_r];
    sts.slot_ready = ready_r[idx_r];
    sts.idx_last   = (idx_r == IDX_W'(SLOTS - 1));
    sts.out_free   = out_free;
    sts.tag_zero   = (tag_r == 8'd0);
    sts.hold_valid = hold_v_r;
  end

  // latch the item on accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_tuser;
      tag_r <= in_tdata[7:0];
      dly_r <= in_tdata[23:8];
      per_r <= in_tdata[39:24];
      tid_r <= in_tdata[47:40];
    end
  end

  // memory write data
  always_comb begin
    mem_we = 1'b0;
    mem_wd = rd_q_r;
    if (cmd.add_take) begin
      mem_we        = 1'b1;
      mem_wd.tag    = tag_r;
      mem_wd.delay  = dly_r;
      mem_wd.period = per_r;
    end else if (cmd.tick_upd && rd_q_r.delay != 16'd0) begin
      mem_we       = 1'b1;
      mem_wd.delay = rd_q_r.delay - 16'd1;
    end else if (cmd.disp_upd && rd_q_r.period != 16'd0) begin
      mem_we       = 1'b1;
      mem_wd.delay = rd_q_r.period;
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= mem_wd;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[idx_r];
    end
  end

  // slot index and flag bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      used_r  <= '0;
      ready_r <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.add_take) begin
        used_r[idx_r]  <= 1'b1;
        ready_r[idx_r] <= 1'b0;
      end
      if (cmd.tick_upd && rd_q_r.delay == 16'd0) begin
        ready_r[idx_r] <= 1'b1;
      end
      if (cmd.disp_upd) begin
        ready_r[idx_r] <= 1'b0;
        if (rd_q_r.period == 16'd0) begin
          used_r[idx_r] <= 1'b0;
        end
      end
      if (cmd.push == PUSH_DEL && del_ok) begin
        used_r[del_idx]  <= 1'b0;
        ready_r[del_idx] <= 1'b0;
      end
    end
  end

  // held dispatch result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (cmd.accept) begin
      hold_v_r <= 1'b0;
    end else if (cmd.disp_upd) begin
      hold_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.disp_upd) begin
      hold_id_r  <= cur_id;
      hold_tag_r <= rd_q_r.tag;
    end
  end

  // result selection
  always_comb begin
    push_v    = 1'b1;
    push_id   = '0;
    push_tag  = '0;
    push_ok   = 1'b0;
    push_last = 1'b1;
    case (cmd.push)
      PUSH_ADD_OK: begin
        push_id = cur_id;
        push_ok = 1'b1;
      end
      PUSH_FAIL: begin
        push_ok = 1'b0;
      end
      PUSH_DEL: begin
        push_id = del_ok ? tid_r[6:0] : 7'd0;
        push_ok = del_ok;
      end
      PUSH_HOLD: begin
        push_id   = hold_id_r;
        push_tag  = hold_tag_r;
        push_ok   = 1'b1;
        push_last = 1'b0;
      end
      PUSH_FINAL: begin
        if (hold_v_r) begin
          push_id  = hold_id_r;
          push_tag = hold_tag_r;
          push_ok  = 1'b1;
        end
      end
      default: begin
        push_v = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push_v) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_v) begin
      out_id_r   <= push_id;
      out_tag_r  <= push_tag;
      out_ok_r   <= push_ok;
      out_last_r <= push_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_ok_r, out_tag_r, out_id_r};
  assign out_tlast  = out_last_r;

endmodule

[src/tick_task_scheduler.sv]
`timescale 1ns / 1ps

// Cooperative tick task scheduler with SLOTS task slots. in_tuser selects the
// operation: tick, dispatch, add or delete. Tick, dispatch and add walk the
// slots in id order, reading from the single-port table memory the entry of
// each slot that needs it (every used slot on a tick, every ready slot on a
// dispatch), then close with a final step; an add stops at the first free
// slot. A delete skips the walk. Dispatch emits one beat per ready slot with
// tlast on the final one, or a single all-zero beat with tlast when nothing
// is ready. Add and delete each give one beat. Slot ids run from 1 to SLOTS
// and never move. The next item is taken once the current one has finished,
// even while its last result still waits in the output register.
module tick_task_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // task_tag[7:0], start_delay[23:8], repeat_period[39:24], target_id[47:40]
  input  logic [tts_pkg::IN_W-1:0]    in_tdata,
  // operation[1:0]
  input  logic [tts_pkg::OP_W-1:0]    in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // slot_id[6:0], run_tag[14:7], ok[15]
  output logic [tts_pkg::OUT_W-1:0]   out_tdata,
  output logic                        out_tlast
);
  import tts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tts_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
